[hdl/hsv_to_rgb_converter_macros.svh]
// Assertion macros used by the checker file of the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define HSV2RGB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, on the usual clock and reset names.
`define HSV2RGB_ASSERT(lbl, prop, msg) `HSV2RGB_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

[hdl/hsv2rgb_pkg.sv]
// Constants and types of the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int LEVEL_FRAC_BITS = 12;
    localparam int HUE_FRAC_BITS   = 6;

    localparam int HUE_W   = 16;
    localparam int LEVEL_W = 13;
    localparam int CHAN_W  = 8;

    localparam int LVL_ONE      = 1 << LEVEL_FRAC_BITS;
    localparam int NUM_SECTORS  = 6;
    localparam int SECTOR_UNITS = 60 << HUE_FRAC_BITS;
    localparam int CIRCLE_UNITS = NUM_SECTORS * SECTOR_UNITS;

    localparam int SEC_W = $clog2(NUM_SECTORS);
    localparam int CIR_W = $clog2(CIRCLE_UNITS);
    localparam int R_W   = $clog2(SECTOR_UNITS);
    localparam int SR_W  = LEVEL_W + R_W;
    localparam int BB_W  = LEVEL_W + CHAN_W;

    localparam longint SD = longint'(LVL_ONE) * longint'(SECTOR_UNITS);
    localparam int T_W    = $clog2(SD + 1);
    localparam int N_W    = BB_W + T_W;

    // S*S*D = 15 << (2L + H + 2)
    localparam int DIV_SHIFT   = 2 * LEVEL_FRAC_BITS + HUE_FRAC_BITS + 2;
    localparam int Y_W         = N_W - DIV_SHIFT;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + 14) / 15;
    localparam int RECIP_W     = $clog2(RECIP + 1);

    localparam int PIPE_DEPTH = 6;

    typedef enum logic [SEC_W-1:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector              sector;
        logic [R_W-1:0]       rem;
        logic [LEVEL_W-1:0]   sat;
        logic [LEVEL_W-1:0]   bri;
    } t_hue_out;

    typedef struct packed {
        t_sector              sector;
        logic                 grey;
        logic [BB_W-1:0]      bb;
        logic [T_W-1:0]       ta;
        logic [T_W-1:0]       tp;
        logic [T_W-1:0]       tq;
    } t_term_out;

endpackage

[hdl/hsv2rgb_ifs.sv]
// Pixel transaction interfaces: HSV input and RGB output.
interface hsv2rgb_pix_if;
    logic                                  valid;
    logic                                  ready;
    logic [hsv2rgb_pkg::HUE_W-1:0]         hue;
    logic [hsv2rgb_pkg::LEVEL_W-1:0]       saturation;
    logic [hsv2rgb_pkg::LEVEL_W-1:0]       brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
    logic                                  valid;
    logic                                  ready;
    logic [hsv2rgb_pkg::CHAN_W-1:0]        red;
    logic [hsv2rgb_pkg::CHAN_W-1:0]        green;
    logic [hsv2rgb_pkg::CHAN_W-1:0]        blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

[hdl/hsv_to_rgb_converter.sv]
// HSV to RGB converter top level: three two-stage sections in a row.
// Converts one pixel per clock while the sink accepts output; each accepted input
// transaction yields one output transaction. Every stage has its own valid bit and is
// refilled as soon as the stage after it moves on, so bubbles close up and an output
// held back by the sink stalls only the stages that are full. Hue is wrapped to one
// circle and cut into its 60 degree sector in stages one and two, the s*r product is
// taken in stage three, the three 45-bit channel products in stage five and the
// exact floor division plus sector routing in stage six. Saturation and brightness
// above 1.0 are treated as 1.0.
module hsv_to_rgb_converter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hsv2rgb_pix_if.sink    i_pix,
    hsv2rgb_rgb_if.source  o_rgb
);

    logic                   w_hue_valid, w_hue_ready;
    hsv2rgb_pkg::t_hue_out  w_hue_data;
    logic                   w_term_valid, w_term_ready;
    hsv2rgb_pkg::t_term_out w_term_data;

    hsv2rgb_hue u_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_hue   (i_pix.hue),
        .i_sat   (i_pix.saturation),
        .i_bri   (i_pix.brightness),
        .o_valid (w_hue_valid),
        .i_ready (w_hue_ready),
        .o_data  (w_hue_data)
    );

    hsv2rgb_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_hue_valid),
        .o_ready (w_hue_ready),
        .i_data  (w_hue_data),
        .o_valid (w_term_valid),
        .i_ready (w_term_ready),
        .o_data  (w_term_data)
    );

    hsv2rgb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_term_valid),
        .o_ready (w_term_ready),
        .i_data  (w_term_data),
        .o_valid (o_rgb.valid),
        .i_ready (o_rgb.ready),
        .o_red   (o_rgb.red),
        .o_green (o_rgb.green),
        .o_blue  (o_rgb.blue)
    );

endmodule

[hdl/hsv2rgb_hue.sv]
// Hue wrap, level clamp, sector and in-sector remainder (two stages).
module hsv2rgb_hue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]      i_hue,
    input  logic [hsv2rgb_pkg::LEVEL_W-1:0]    i_sat,
    input  logic [hsv2rgb_pkg::LEVEL_W-1:0]    i_bri,
    output logic                               o_valid,
    input  logic                               i_ready,
    output hsv2rgb_pkg::t_hue_out              o_data
);

    typedef struct packed {
        logic [hsv2rgb_pkg::CIR_W-1:0]   hue;
        logic [hsv2rgb_pkg::LEVEL_W-1:0] sat;
        logic [hsv2rgb_pkg::LEVEL_W-1:0] bri;
    } t_wrap;

    logic                   r_va, r_vb;
    t_wrap                  r_a, n_a;
    hsv2rgb_pkg::t_hue_out  r_b, n_b;
    logic                   w_rdy_a, w_rdy_b;
    logic [hsv2rgb_pkg::SEC_W-1:0] w_sec;
    logic [hsv2rgb_pkg::CIR_W-1:0] w_base;

    assign w_rdy_b = !r_vb || i_ready;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vb;
    assign o_data  = r_b;

    always_comb begin
        if (int'(i_hue) >= 2 * hsv2rgb_pkg::CIRCLE_UNITS) begin
            n_a.hue = hsv2rgb_pkg::CIR_W'(int'(i_hue) - 2 * hsv2rgb_pkg::CIRCLE_UNITS);
        end else if (int'(i_hue) >= hsv2rgb_pkg::CIRCLE_UNITS) begin
            n_a.hue = hsv2rgb_pkg::CIR_W'(int'(i_hue) - hsv2rgb_pkg::CIRCLE_UNITS);
        end else begin
            n_a.hue = hsv2rgb_pkg::CIR_W'(i_hue);
        end
        n_a.sat = (int'(i_sat) > hsv2rgb_pkg::LVL_ONE) ?
                  hsv2rgb_pkg::LEVEL_W'(hsv2rgb_pkg::LVL_ONE) : i_sat;
        n_a.bri = (int'(i_bri) > hsv2rgb_pkg::LVL_ONE) ?
                  hsv2rgb_pkg::LEVEL_W'(hsv2rgb_pkg::LVL_ONE) : i_bri;
    end

    always_comb begin
        w_sec  = '0;
        w_base = '0;
        for (int k = 1; k < hsv2rgb_pkg::NUM_SECTORS; k++) begin
            if (int'(r_a.hue) >= k * hsv2rgb_pkg::SECTOR_UNITS) begin
                w_sec  = hsv2rgb_pkg::SEC_W'(k);
                w_base = hsv2rgb_pkg::CIR_W'(k * hsv2rgb_pkg::SECTOR_UNITS);
            end
        end
        n_b.sector = hsv2rgb_pkg::t_sector'(w_sec);
        n_b.rem    = hsv2rgb_pkg::R_W'(r_a.hue - w_base);
        n_b.sat    = r_a.sat;
        n_b.bri    = r_a.bri;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a <= n_a;
        end
        if (w_rdy_b && r_va) begin
            r_b <= n_b;
        end
    end

endmodule

[hdl/hsv2rgb_term.sv]
// Term factors 255*b and (1-s), (1-sf), (1-s(1-f)) at the common scale (two stages).
module hsv2rgb_term (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  hsv2rgb_pkg::t_hue_out  i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output hsv2rgb_pkg::t_term_out o_data
);

    typedef struct packed {
        hsv2rgb_pkg::t_sector           sector;
        logic                           grey;
        logic [hsv2rgb_pkg::BB_W-1:0]   bb;
        logic [hsv2rgb_pkg::SR_W-1:0]   sr;
        logic [hsv2rgb_pkg::T_W-1:0]    ta;
    } t_prod;

    logic                   r_va, r_vb;
    t_prod                  r_a, n_a;
    hsv2rgb_pkg::t_term_out r_b, n_b;
    logic                   w_rdy_a, w_rdy_b;

    assign w_rdy_b = !r_vb || i_ready;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vb;
    assign o_data  = r_b;

    always_comb begin
        n_a.sector = i_data.sector;
        n_a.grey   = (i_data.sat == '0);
        n_a.bb     = hsv2rgb_pkg::BB_W'(int'(i_data.bri) * 255);
        n_a.sr     = hsv2rgb_pkg::SR_W'(i_data.sat) * hsv2rgb_pkg::SR_W'(i_data.rem);
        n_a.ta     = hsv2rgb_pkg::T_W'((hsv2rgb_pkg::LVL_ONE - int'(i_data.sat))
                     * hsv2rgb_pkg::SECTOR_UNITS);
    end

    // S*D - s*r for p, D*(S-s) + s*r for q
    always_comb begin
        n_b.sector = r_a.sector;
        n_b.grey   = r_a.grey;
        n_b.bb     = r_a.bb;
        n_b.ta     = r_a.ta;
        n_b.tp     = hsv2rgb_pkg::T_W'(hsv2rgb_pkg::SD - longint'(r_a.sr));
        n_b.tq     = hsv2rgb_pkg::T_W'(longint'(r_a.ta) + longint'(r_a.sr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a <= n_a;
        end
        if (w_rdy_b && r_va) begin
            r_b <= n_b;
        end
    end

endmodule

[hdl/hsv2rgb_scale.sv]
// Channel products, exact floor division and sector routing (two stages).
module hsv2rgb_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  hsv2rgb_pkg::t_term_out            i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_blue
);

    typedef struct packed {
        hsv2rgb_pkg::t_sector            sector;
        logic                            grey;
        logic [hsv2rgb_pkg::CHAN_W-1:0]  vb;
        logic [hsv2rgb_pkg::N_W-1:0]     na;
        logic [hsv2rgb_pkg::N_W-1:0]     np;
        logic [hsv2rgb_pkg::N_W-1:0]     nq;
    } t_num;

    typedef struct packed {
        logic [hsv2rgb_pkg::CHAN_W-1:0] red;
        logic [hsv2rgb_pkg::CHAN_W-1:0] green;
        logic [hsv2rgb_pkg::CHAN_W-1:0] blue;
    } t_rgb;

    logic   r_va, r_vb;
    t_num   r_a, n_a;
    t_rgb   r_b, n_b;
    logic   w_rdy_a, w_rdy_b;
    logic [hsv2rgb_pkg::CHAN_W-1:0] w_va, w_vp, w_vq;

    // floor(n / (15 << DIV_SHIFT)); quotient by 15 through a reciprocal
    function automatic logic [hsv2rgb_pkg::CHAN_W-1:0] div_scale(
        input logic [hsv2rgb_pkg::N_W-1:0] n
    );
        logic [hsv2rgb_pkg::Y_W-1:0]                     y;
        logic [hsv2rgb_pkg::Y_W+hsv2rgb_pkg::RECIP_W-1:0] p;
        y = n[hsv2rgb_pkg::N_W-1:hsv2rgb_pkg::DIV_SHIFT];
        p = (hsv2rgb_pkg::Y_W+hsv2rgb_pkg::RECIP_W)'(y)
            * (hsv2rgb_pkg::Y_W+hsv2rgb_pkg::RECIP_W)'(hsv2rgb_pkg::RECIP);
        return p[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CHAN_W];
    endfunction

    assign w_rdy_b = !r_vb || i_ready;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vb;
    assign o_red   = r_b.red;
    assign o_green = r_b.green;
    assign o_blue  = r_b.blue;

    always_comb begin
        n_a.sector = i_data.sector;
        n_a.grey   = i_data.grey;
        n_a.vb     = i_data.bb[hsv2rgb_pkg::LEVEL_FRAC_BITS +: hsv2rgb_pkg::CHAN_W];
        n_a.na     = hsv2rgb_pkg::N_W'(i_data.bb) * hsv2rgb_pkg::N_W'(i_data.ta);
        n_a.np     = hsv2rgb_pkg::N_W'(i_data.bb) * hsv2rgb_pkg::N_W'(i_data.tp);
        n_a.nq     = hsv2rgb_pkg::N_W'(i_data.bb) * hsv2rgb_pkg::N_W'(i_data.tq);
    end

    assign w_va = div_scale(r_a.na);
    assign w_vp = div_scale(r_a.np);
    assign w_vq = div_scale(r_a.nq);

    always_comb begin
        if (r_a.grey) begin
            n_b = '{red: r_a.vb, green: r_a.vb, blue: r_a.vb};
        end else begin
            case (r_a.sector)
                hsv2rgb_pkg::SEC_RED_YEL: n_b = '{red: r_a.vb, green: w_vq,    blue: w_va};
                hsv2rgb_pkg::SEC_YEL_GRN: n_b = '{red: w_vp,    green: r_a.vb, blue: w_va};
                hsv2rgb_pkg::SEC_GRN_CYN: n_b = '{red: w_va,    green: r_a.vb, blue: w_vq};
                hsv2rgb_pkg::SEC_CYN_BLU: n_b = '{red: w_va,    green: w_vp,    blue: r_a.vb};
                hsv2rgb_pkg::SEC_BLU_MAG: n_b = '{red: w_vq,    green: w_va,    blue: r_a.vb};
                default:                  n_b = '{red: r_a.vb, green: w_va,    blue: w_vp};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a <= n_a;
        end
        if (w_rdy_b && r_va) begin
            r_b <= n_b;
        end
    end

endmodule

[hdl/hsv2rgb_chk.sv]
// Port-level checker for the HSV to RGB converter and its bind.
`include "hsv_to_rgb_converter_macros.svh"

module hsv2rgb_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]    i_red,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]    i_green,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]    i_blue
);

    localparam int CNT_W = $clog2(hsv2rgb_pkg::PIPE_DEPTH + 2);

    logic [CNT_W-1:0] r_cnt, n_cnt;

    // transactions in flight
    assign n_cnt = r_cnt + CNT_W'(i_in_valid && i_in_ready)
                         - CNT_W'(i_out_valid && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `HSV2RGB_ASSERT(a_out_hold, (i_out_valid && !i_out_ready) |=> i_out_valid, "output valid dropped while stalled")
    `HSV2RGB_ASSERT(a_out_stable, (i_out_valid && !i_out_ready) |=> ($stable(i_red) && $stable(i_green) && $stable(i_blue)), "output pixel changed while stalled")
    `HSV2RGB_ASSERT(a_depth, r_cnt <= CNT_W'(hsv2rgb_pkg::PIPE_DEPTH), "more transactions in flight than stages")
    `HSV2RGB_ASSERT(a_no_phantom, i_out_valid |-> (r_cnt != '0), "output transaction without an input")

endmodule

bind hsv_to_rgb_converter hsv2rgb_chk u_hsv2rgb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);
